@@ hdl/tssp_pkg.sv @@
// Shared types and constants for the transport stream section packetizer.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package tssp_pkg;

    localparam logic [7:0] SYNC_BYTE = 8'h47;
    localparam logic [7:0] PKT_BYTES = 8'd188;
    localparam logic [7:0] FILL_BYTE = 8'hFF;
    localparam logic [7:0] PTR_BYTE = 8'h00;

    // Position of a section's first byte in its first packet (after header and pointer field), and the header length.
    localparam logic [7:0] FIRST_PAYLOAD_POS = 8'd5;
    localparam logic [7:0] HEADER_BYTES = 8'd4;

    // Configuration register indexes.
    localparam logic [1:0] REG_PACKET_ID = 2'd0;
    localparam logic [1:0] REG_PRIORITY = 2'd1;
    localparam logic [1:0] REG_ADAPTATION = 2'd2;

    localparam int unsigned QUEUE_DEPTH = 4;

    typedef struct packed {
        logic [12:0] packet_id;
        logic        priority_bit;
        logic [1:0]  adaptation_control;
    } t_cfg;

    // One section byte as classified by the front end.
    typedef struct packed {
        logic [7:0] data;
        logic       first;      // opens a new section
        logic       last_byte;  // closes the section, padding follows
        logic [3:0] sel;        // counter selector, already reduced
    } t_cmd;

endpackage

`default_nettype wire

@@ hdl/tssp_front.sv @@
// Input front end: tracks section framing, drops bytes outside a section
// and reduces the counter selector. Depends on tssp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tssp_front #(
    parameter int unsigned NUM_COUNTERS = 16
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_stall,
    input  wire logic [7:0]    i_section_byte,
    input  wire logic          i_section_start,
    input  wire logic          i_section_end,
    input  wire logic [3:0]    i_counter_select,
    input  wire logic          i_q_full,
    output logic               o_q_push,
    output tssp_pkg::t_cmd     o_q_data
);
    import tssp_pkg::*;

    logic       r_in_section;
    logic       n_in_section;
    logic       accept;
    logic       keep;
    logic [3:0] sel_mod [16];

    // Selector reduction table, built at elaboration.
    for (genvar g = 0; g < 16; g++) begin : g_sel
        localparam int unsigned MODV = g % NUM_COUNTERS;
        assign sel_mod[g] = 4'(MODV);
    end

    assign o_in_stall = i_q_full;
    assign accept     = i_in_valid & ~i_q_full;
    assign keep       = r_in_section | i_section_start;
    assign o_q_push   = accept & keep;

    always_comb begin
        o_q_data.data      = i_section_byte;
        o_q_data.first     = ~r_in_section;
        o_q_data.last_byte = i_section_end;
        o_q_data.sel       = sel_mod[i_counter_select];
        n_in_section       = r_in_section;
        if (o_q_push) begin
            n_in_section = ~i_section_end;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_section <= 1'b0;
        end else begin
            r_in_section <= n_in_section;
        end
    end

endmodule

`default_nettype wire

@@ hdl/tssp_queue.sv @@
// Short first-in first-out queue of classified section bytes between
// the front end and the packet builder. Depends on tssp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tssp_queue (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  wire tssp_pkg::t_cmd i_data,
    output logic               o_full,
    input  wire logic          i_pop,
    output tssp_pkg::t_cmd     o_data,
    output logic               o_not_empty
);
    import tssp_pkg::*;

    localparam int unsigned PW = $clog2(QUEUE_DEPTH);

    t_cmd          r_mem [QUEUE_DEPTH];
    logic [PW-1:0] r_wr_ptr;
    logic [PW-1:0] r_rd_ptr;
    logic [PW:0]   r_count;
    logic          do_push;
    logic          do_pop;

    assign o_full      = (r_count == (PW + 1)'(QUEUE_DEPTH));
    assign o_not_empty = (r_count != '0);
    assign o_data      = r_mem[r_rd_ptr];
    assign do_push     = i_push & ~o_full;
    assign do_pop      = i_pop & o_not_empty;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

@@ hdl/tssp_back.sv @@
// Packet builder: turns queued section bytes into 32-bit packet words,
// inserting headers and fill, and keeps the continuity counter store.
// Depends on tssp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tssp_back #(
    parameter int unsigned NUM_COUNTERS = 16
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire tssp_pkg::t_cfg i_cfg,
    input  wire tssp_pkg::t_cmd i_q_data,
    input  wire logic          i_q_not_empty,
    output logic               o_q_pop,
    output logic               o_out_valid,
    input  wire logic          i_out_stall,
    output logic [31:0]        o_packet_word,
    output logic               o_packet_end,
    output logic               o_last
);
    import tssp_pkg::*;

    localparam int unsigned CW = (NUM_COUNTERS > 1) ? $clog2(NUM_COUNTERS) : 1;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_LOAD = 3'd1;
    localparam logic [2:0] S_HDR  = 3'd2;
    localparam logic [2:0] S_DATA = 3'd3;
    localparam logic [2:0] S_PAD  = 3'd4;

    logic [2:0]              r_state, n_state;
    t_cmd                    r_cmd, n_cmd;
    logic [7:0]              r_pos, n_pos;
    logic [23:0]             r_acc, n_acc;
    logic [CW-1:0]           r_act, n_act;
    logic [3:0]              r_cc, n_cc;

    logic [3:0]              r_cc_mem [NUM_COUNTERS];
    logic [NUM_COUNTERS-1:0] r_cc_vld;
    logic [3:0]              r_cc_rd;
    logic                    r_rd_vld;
    logic [CW-1:0]           rd_addr;
    logic                    cc_we;

    logic                    r_o_vld;
    logic [31:0]             r_o_word;
    logic                    r_o_end;
    logic                    r_o_last;

    logic                    out_free;
    logic                    emit;
    logic [31:0]             e_word;
    logic                    e_end;
    logic                    e_last;
    logic [7:0]              pos_inc;
    logic [7:0]              pos_up;
    logic                    pkt_done;

    assign out_free = ~r_o_vld | ~i_out_stall;
    assign rd_addr  = CW'(i_q_data.sel);
    assign pos_inc  = r_pos + 8'd1;
    assign pos_up   = {r_pos[7:2] + 6'd1, 2'b00};

    always_comb begin
        n_state  = r_state;
        n_cmd    = r_cmd;
        n_pos    = r_pos;
        n_acc    = r_acc;
        n_act    = r_act;
        n_cc     = r_cc;
        o_q_pop  = 1'b0;
        cc_we    = 1'b0;
        emit     = 1'b0;
        e_word   = '0;
        e_end    = 1'b0;
        e_last   = 1'b0;
        pkt_done = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_q_pop = i_q_not_empty;
                if (i_q_not_empty) begin
                    n_cmd = i_q_data;
                    if (i_q_data.first) begin
                        n_act   = rd_addr;
                        n_pos   = '0;
                        n_state = S_LOAD;
                    end else if (r_pos == '0) begin
                        n_state = S_HDR;
                    end else begin
                        n_state = S_DATA;
                    end
                end
            end
            S_LOAD: begin
                n_cc    = r_rd_vld ? r_cc_rd : 4'd0;
                n_state = S_HDR;
            end
            S_HDR: begin
                if (out_free) begin
                    emit   = 1'b1;
                    e_word = {SYNC_BYTE,
                              1'b0, r_cmd.first, i_cfg.priority_bit, i_cfg.packet_id[12:8],
                              i_cfg.packet_id[7:0],
                              2'b00, i_cfg.adaptation_control, r_cc};
                    // The section byte that follows never completes a word.
                    e_last = ~r_cmd.last_byte;
                    cc_we  = 1'b1;
                    n_cc   = r_cc + 4'd1;
                    if (r_cmd.first) begin
                        n_acc = {16'h0000, PTR_BYTE};
                        n_pos = FIRST_PAYLOAD_POS;
                    end else begin
                        n_pos = HEADER_BYTES;
                    end
                    n_state = S_DATA;
                end
            end
            S_DATA: begin
                if (pos_inc[1:0] == 2'b00) begin
                    if (out_free) begin
                        pkt_done = (pos_inc == PKT_BYTES);
                        emit     = 1'b1;
                        e_word   = {r_acc, r_cmd.data};
                        e_end    = pkt_done;
                        e_last   = ~r_cmd.last_byte | pkt_done;
                        n_pos    = pkt_done ? 8'd0 : pos_inc;
                        n_state  = (r_cmd.last_byte && !pkt_done) ? S_PAD : S_IDLE;
                    end
                end else begin
                    n_acc   = {r_acc[15:0], r_cmd.data};
                    n_pos   = pos_inc;
                    n_state = r_cmd.last_byte ? S_PAD : S_IDLE;
                end
            end
            S_PAD: begin
                if (out_free) begin
                    pkt_done = (pos_up == PKT_BYTES);
                    emit     = 1'b1;
                    case (r_pos[1:0])
                        2'd1:    e_word = {r_acc[7:0], {3{FILL_BYTE}}};
                        2'd2:    e_word = {r_acc[15:0], {2{FILL_BYTE}}};
                        2'd3:    e_word = {r_acc[23:0], FILL_BYTE};
                        default: e_word = {4{FILL_BYTE}};
                    endcase
                    e_end   = pkt_done;
                    e_last  = pkt_done;
                    n_pos   = pkt_done ? 8'd0 : pos_up;
                    n_state = pkt_done ? S_IDLE : S_PAD;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Counter store: written on each header, read when a section opens.
    always_ff @(posedge i_clk) begin
        if (cc_we) begin
            r_cc_mem[r_act] <= r_cc + 4'd1;
        end
        r_cc_rd <= r_cc_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cc_vld <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            if (cc_we) begin
                r_cc_vld[r_act] <= 1'b1;
            end
            r_rd_vld <= r_cc_vld[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_pos   <= '0;
            r_act   <= '0;
            r_cc    <= '0;
            r_o_vld <= 1'b0;
        end else begin
            r_state <= n_state;
            r_pos   <= n_pos;
            r_act   <= n_act;
            r_cc    <= n_cc;
            if (emit) begin
                r_o_vld <= 1'b1;
            end else if (!i_out_stall) begin
                r_o_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd <= n_cmd;
        r_acc <= n_acc;
        if (emit) begin
            r_o_word <= e_word;
            r_o_end  <= e_end;
            r_o_last <= e_last;
        end
    end

    assign o_out_valid   = r_o_vld;
    assign o_packet_word = r_o_word;
    assign o_packet_end  = r_o_end;
    assign o_last        = r_o_last;

endmodule

`default_nettype wire

@@ hdl/ts_section_packetizer.sv @@
// Each section byte passes the queue, then the builder's fetch (idle) and pack (data) steps;
// a byte that opens a packet also passes the header state, and one that opens a section
// the load and header states. After a section's last byte, fill words (up to 46) follow
// to the packet's end. The queue lets the front end take new bytes while the builder is busy.
// Reset: synchronous, active low; clears framing, queue, counter store and output valid.
// Top level of the transport stream section packetizer; uses tssp_pkg and all tssp_ modules.
`timescale 1ns / 1ps
`default_nettype none

module ts_section_packetizer #(
    parameter int unsigned NUM_COUNTERS = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_idx,
    input  wire logic [12:0] i_cfg_data,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic [7:0]  i_section_byte,
    input  wire logic        i_section_start,
    input  wire logic        i_section_end,
    input  wire logic [3:0]  i_counter_select,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic [31:0]      o_packet_word,
    output logic             o_packet_end,
    output logic             o_last
);
    import tssp_pkg::*;

    t_cfg r_cfg;
    t_cmd push_data;
    t_cmd pop_data;
    logic q_push;
    logic q_full;
    logic q_pop;
    logic q_not_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.packet_id          <= 13'd0;
            r_cfg.priority_bit       <= 1'b0;
            r_cfg.adaptation_control <= 2'd1;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_PACKET_ID:  r_cfg.packet_id          <= i_cfg_data;
                REG_PRIORITY:   r_cfg.priority_bit       <= i_cfg_data[0];
                REG_ADAPTATION: r_cfg.adaptation_control <= i_cfg_data[1:0];
                default: ;
            endcase
        end
    end

    tssp_front #(
        .NUM_COUNTERS(NUM_COUNTERS)
    ) u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_section_byte   (i_section_byte),
        .i_section_start  (i_section_start),
        .i_section_end    (i_section_end),
        .i_counter_select (i_counter_select),
        .i_q_full         (q_full),
        .o_q_push         (q_push),
        .o_q_data         (push_data)
    );

    tssp_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (q_push),
        .i_data      (push_data),
        .o_full      (q_full),
        .i_pop       (q_pop),
        .o_data      (pop_data),
        .o_not_empty (q_not_empty)
    );

    tssp_back #(
        .NUM_COUNTERS(NUM_COUNTERS)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (r_cfg),
        .i_q_data      (pop_data),
        .i_q_not_empty (q_not_empty),
        .o_q_pop       (q_pop),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_packet_word (o_packet_word),
        .o_packet_end  (o_packet_end),
        .o_last        (o_last)
    );

endmodule

`default_nettype wire

@@ tb/sv/tb.sv @@
// Self-checking testbench for ts_section_packetizer: section bytes in, packet words out.
// Depends on tssp_pkg and the packetizer RTL; an internal predictor computes every
// expected word.
`timescale 1ns / 1ps

module tb;
    import tssp_pkg::*;

    localparam logic [1:0] REG_UNUSED = 2'd3;
    localparam int unsigned DRAIN_CYCLES = 16;
    localparam int unsigned CYCLE_LIMIT = 400000;

    typedef struct packed {
        logic [31:0] word;
        logic        pend;
        logic        last;
    } t_packet_word;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [1:0]  i_cfg_idx;
    logic [12:0] i_cfg_data;
    logic        i_in_valid;
    logic        o_in_stall;
    logic [7:0]  i_section_byte;
    logic        i_section_start;
    logic        i_section_end;
    logic [3:0]  i_counter_select;
    logic        o_out_valid;
    logic        i_out_stall;
    logic [31:0] o_packet_word;
    logic        o_packet_end;
    logic        o_last;

    // Predictor state: configuration, continuity counters and packet framing.
    t_cfg         cfg;
    logic [3:0]   cc_store [16];
    int unsigned  pkt_pos;
    logic [31:0]  acc;
    logic [3:0]   cur_counter;
    bit           open_section;
    t_packet_word expected_words[$];
    t_packet_word want;

    int unsigned gap_pct = 0;
    int unsigned stall_pct = 0;
    int unsigned errors = 0;
    int unsigned cycle_count = 0;

    ts_section_packetizer i_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_idx        (i_cfg_idx),
        .i_cfg_data       (i_cfg_data),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_section_byte   (i_section_byte),
        .i_section_start  (i_section_start),
        .i_section_end    (i_section_end),
        .i_counter_select (i_counter_select),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_packet_word    (o_packet_word),
        .o_packet_end     (o_packet_end),
        .o_last           (o_last)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(negedge i_clk) begin
        i_out_stall <= ($urandom_range(0, 99) < stall_pct);
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("[ts_section_packetizer] ERROR");
            $finish;
        end
    end

    // Appends one byte to the packet being built; every fourth byte completes a word.
    function automatic void pack_byte(input logic [7:0] value);
        t_packet_word w;
        acc = {acc[23:0], value};
        pkt_pos++;
        if (pkt_pos % 4 == 0) begin
            w.word = acc;
            w.pend = (pkt_pos >= PKT_BYTES);
            w.last = 1'b0;
            expected_words = {expected_words, w};
            acc = '0;
            if (pkt_pos >= PKT_BYTES) begin
                pkt_pos = 0;
            end
        end
    endfunction

    function automatic void pack_header(input logic unit_start);
        logic [3:0] cc;
        cc = cc_store[cur_counter];
        pack_byte(SYNC_BYTE);
        pack_byte({1'b0, unit_start, cfg.priority_bit, cfg.packet_id[12:8]});
        pack_byte(cfg.packet_id[7:0]);
        pack_byte({2'b00, cfg.adaptation_control, cc});
        cc_store[cur_counter] = cc + 4'd1;
    endfunction

    function automatic void packetize_byte(input logic [7:0] value, input logic first,
                                           input logic closing, input logic [3:0] selector);
        int unsigned n0;
        n0 = expected_words.size();
        if (!open_section) begin
            if (!first) begin
                return;
            end
            cur_counter = selector;
            open_section = 1'b1;
            pkt_pos = 0;
            acc = '0;
            pack_header(1'b1);
            pack_byte(PTR_BYTE);
        end else if (pkt_pos == 0) begin
            pack_header(1'b0);
        end
        pack_byte(value);
        if (closing) begin
            while (pkt_pos != 0) begin
                pack_byte(FILL_BYTE);
            end
            open_section = 1'b0;
        end
        if (expected_words.size() > n0) begin
            expected_words[expected_words.size() - 1].last = 1'b1;
        end
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_words.size() == 0) begin
                $display("%0t: word with none expected: expected nothing, actual %h",
                         $time, o_packet_word);
                errors++;
            end else begin
                want = expected_words.pop_front();
                if (o_packet_word !== want.word) begin
                    $display("%0t: packet_word expected %h actual %h",
                             $time, want.word, o_packet_word);
                    errors++;
                end
                if (o_packet_end !== want.pend) begin
                    $display("%0t: packet_end expected %b actual %b",
                             $time, want.pend, o_packet_end);
                    errors++;
                end
                if (o_last !== want.last) begin
                    $display("%0t: last expected %b actual %b", $time, want.last, o_last);
                    errors++;
                end
            end
        end
    end

    task automatic send_byte(input logic [7:0] value, input logic first, input logic closing,
                             input logic [3:0] selector);
        @(negedge i_clk);
        while ($urandom_range(0, 99) < gap_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_section_byte <= value;
        i_section_start <= first;
        i_section_end <= closing;
        i_counter_select <= selector;
        @(posedge i_clk);
        while (o_in_stall) begin
            @(posedge i_clk);
        end
        packetize_byte(value, first, closing, selector);
    endtask

    // A well-formed section with random content; stray start marks and selectors
    // on later bytes must be ignored by the block.
    task automatic send_section(input int unsigned len, input int unsigned noise_pct);
        logic [3:0] selector;
        logic       first;
        selector = ($urandom_range(0, 99) < 70) ? 4'($urandom_range(0, 1))
                                                : 4'($urandom_range(0, 15));
        for (int unsigned i = 0; i < len; i++) begin
            first = (i == 0) || ($urandom_range(0, 99) < noise_pct);
            send_byte(8'($urandom_range(0, 255)), first, i == len - 1,
                      (i == 0) ? selector : 4'($urandom_range(0, 15)));
        end
    endtask

    // Register writes are only made with no transfer in flight.
    task automatic wait_for_drain();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (expected_words.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_register(input logic [1:0] idx, input logic [12:0] data);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= data;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            REG_PACKET_ID:  cfg.packet_id = data;
            REG_PRIORITY:   cfg.priority_bit = data[0];
            REG_ADAPTATION: cfg.adaptation_control = data[1:0];
            default: ;
        endcase
    endtask

    task automatic test_outside_bytes();
        send_byte(8'hFF, 1'b0, 1'b1, 4'd15);
        send_byte(8'h00, 1'b0, 1'b0, 4'd0);
    endtask

    task automatic test_field_extremes();
        send_byte(8'hFF, 1'b1, 1'b1, 4'd15);
        send_byte(8'h00, 1'b1, 1'b0, 4'd0);
        send_byte(8'hFF, 1'b0, 1'b1, 4'd0);
    endtask

    task automatic test_start_inside_section();
        send_byte(8'hA5, 1'b1, 1'b0, 4'd3);
        send_byte(8'h5A, 1'b1, 1'b0, 4'd9);
        send_byte(8'h3C, 1'b1, 1'b1, 4'd12);
    endtask

    task automatic test_register_writes();
        wait_for_drain();
        write_register(REG_PACKET_ID, 13'h1FFF);
        write_register(REG_PRIORITY, 13'h0001);
        write_register(REG_ADAPTATION, 13'h0003);
        write_register(REG_UNUSED, 13'h1FFF);
        send_byte(8'h81, 1'b1, 1'b0, 4'd9);
        send_byte(8'h7E, 1'b0, 1'b1, 4'd9);
        wait_for_drain();
        write_register(REG_PACKET_ID, 13'h0000);
        write_register(REG_PRIORITY, 13'h1FFE);
        write_register(REG_ADAPTATION, 13'h1FFC);
        send_byte(8'h12, 1'b1, 1'b1, 4'd9);
        wait_for_drain();
        write_register(REG_ADAPTATION, 13'h0002);
        send_byte(8'h34, 1'b1, 1'b1, 4'd15);
    endtask

    task automatic test_random_sections(input int unsigned gap, input int unsigned stall,
                                        input int unsigned target, input bit with_boundary);
        int unsigned sent;
        int unsigned len;
        int unsigned roll;
        sent = 0;
        wait_for_drain();
        gap_pct = gap;
        stall_pct = stall;
        write_register(REG_PACKET_ID, 13'($urandom_range(0, 8191)));
        write_register(REG_PRIORITY, 13'($urandom_range(0, 8191)));
        write_register(REG_ADAPTATION, 13'($urandom_range(0, 8191)));
        // The first packet carries 183 section bytes after the pointer field,
        // so this section ends exactly on a packet boundary.
        if (with_boundary) begin
            send_section(183, 0);
            sent += 183;
        end
        while (sent < target) begin
            roll = $urandom_range(0, 99);
            if (roll < 70) begin
                len = $urandom_range(1, 8);
            end else if (roll < 95) begin
                len = $urandom_range(9, 40);
            end else begin
                len = $urandom_range(150, 250);
            end
            // Keep the byte count of this phase at its target.
            if (len > target - sent) begin
                len = target - sent;
            end
            send_section(len, 10);
            sent += len;
            roll = $urandom_range(0, 99);
            if (roll < 15) begin
                repeat ($urandom_range(1, 2)) begin
                    send_byte(8'($urandom_range(0, 255)), 1'b0, 1'($urandom_range(0, 1)),
                              4'($urandom_range(0, 15)));
                end
            end else if (roll < 25) begin
                wait_for_drain();
                write_register(2'($urandom_range(0, 3)), 13'($urandom_range(0, 8191)));
            end
        end
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = REG_PACKET_ID;
        i_cfg_data = '0;
        i_in_valid = 1'b0;
        i_section_byte = '0;
        i_section_start = 1'b0;
        i_section_end = 1'b0;
        i_counter_select = '0;
        cfg = '{packet_id: 13'd0, priority_bit: 1'b0, adaptation_control: 2'd1};
        for (int i = 0; i < 16; i++) begin
            cc_store[i] = 4'd0;
        end
        pkt_pos = 0;
        acc = '0;
        cur_counter = '0;
        open_section = 1'b0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_outside_bytes();
        test_field_extremes();
        test_start_inside_section();
        test_register_writes();
        test_random_sections(32, 83, 40, 1'b0);
        test_random_sections(83, 32, 200, 1'b1);
        test_random_sections(0, 0, 40, 1'b0);
        wait_for_drain();

        if (errors == 0) begin
            $display("[ts_section_packetizer] OK");
        end else begin
            $display("[ts_section_packetizer] ERROR");
        end
        $finish;
    end

endmodule

@@ ts_section_packetizer.f @@
hdl/tssp_pkg.sv
hdl/tssp_front.sv
hdl/tssp_queue.sv
hdl/tssp_back.sv
hdl/ts_section_packetizer.sv
tb/sv/tb.sv
